// ===== src/bitmap_frame_allocator_macros.svh =====
// assertion macros used by the frame allocator top level
`ifndef BITMAP_FRAME_ALLOCATOR_MACROS_SVH
`define BITMAP_FRAME_ALLOCATOR_MACROS_SVH

// same-cycle implication, checked outside reset
`define BFA_ASSERT_NOW(label, clk, rstn, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) else $error(msg);

// next-cycle implication, checked outside reset
`define BFA_ASSERT_NEXT(label, clk, rstn, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) else $error(msg);

`endif

// ===== src/bfa_pkg.sv =====
// types, constants and helpers of the bitmap frame allocator
`default_nettype none

package bfa_pkg;

  localparam int unsigned FrameBytes  = 4096;
  localparam int unsigned BitmapBytes = 1024;
  localparam int unsigned AddrW       = 25;

  localparam int unsigned FrameShift = $clog2(FrameBytes);
  localparam int unsigned ByteIdxW   = $clog2(BitmapBytes);
  localparam int unsigned FrameW     = ByteIdxW + 3;
  localparam longint unsigned FrameLimit =
    longint'(FrameBytes) * 64'd8 * longint'(BitmapBytes);

  typedef enum logic [1:0] {
    FUNC_ALLOC   = 2'd0,
    FUNC_FREE    = 2'd1,
    FUNC_QUERY   = 2'd2,
    FUNC_RESERVE = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_NO_FRAME = 2'd1,
    STAT_BAD_ADDR = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RMW,
    ST_SCAN,
    ST_RESP
  } state_e;

  typedef struct packed {
    func_e              func;
    logic [AddrW-1:0]   req_addr;
  } in_t;

  typedef struct packed {
    logic [AddrW-1:0]   result_addr;
    status_e            status;
    logic               frame_free;
  } out_t;

  // everything derived from one bitmap byte
  typedef struct packed {
    logic [7:0] set_data;   // byte with the addressed bit set
    logic [7:0] clr_data;   // byte with the addressed bit cleared
    logic [7:0] take_data;  // byte with its lowest free bit set
    logic       full;
    logic [2:0] low_bit;
    logic       bit_set;
  } byte_info_t;

  function automatic logic addr_ok(logic [AddrW-1:0] addr);
    logic [63:0] wide;
    wide = 64'(addr);
    return (wide < FrameLimit) && (addr[FrameShift-1:0] == '0);
  endfunction

  function automatic logic [FrameW-1:0] addr_to_frame(logic [AddrW-1:0] addr);
    return FrameW'(addr >> FrameShift);
  endfunction

  function automatic logic [AddrW-1:0] frame_to_addr(logic [FrameW-1:0] frame);
    logic [FrameW+FrameShift-1:0] full_addr;
    full_addr = {frame, {FrameShift{1'b0}}};
    return AddrW'(full_addr);
  endfunction

endpackage

`default_nettype wire

// ===== src/bfa_ram.sv =====
// generic single-port-write, registered-read ram
`default_nettype none

module bfa_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output      logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== src/bfa_byte_logic.sv =====
// bit operations on one bitmap byte: set, clear, test, lowest free bit
`default_nettype none

module bfa_byte_logic
  import bfa_pkg::*;
(
  input  wire logic [7:0] byte_i,
  input  wire logic [2:0] bit_i,
  output      byte_info_t info_o
);

  logic [7:0] mask;
  logic [2:0] low_bit;

  assign mask = 8'b1 << bit_i;

  // lowest clear bit, scanning down so bit 0 wins
  always_comb begin
    low_bit = 3'd0;
    for (int i = 7; i >= 0; i--) begin
      if (!byte_i[i]) begin
        low_bit = 3'(i);
      end
    end
  end

  always_comb begin
    info_o.set_data  = byte_i | mask;
    info_o.clr_data  = byte_i & ~mask;
    info_o.take_data = byte_i | (8'b1 << low_bit);
    info_o.full      = (byte_i == 8'hFF);
    info_o.low_bit   = low_bit;
    info_o.bit_set   = |(byte_i & mask);
  end

endmodule

`default_nettype wire

// ===== src/bitmap_frame_allocator.sv =====
// top level of the bitmap frame allocator: control, scan and bitmap memory
//
// Physical frame allocator with one used bit per frame held in a 1024 x 8
// bitmap ram (8192 frames of 4 KiB, byte address in 25 bits). After reset a
// clearing pass writes every bitmap byte to zero, one byte per cycle, so the
// block accepts no beat until the pass is done. Items are handled one at a
// time. Free and mark-used take one bitmap read and one write-back; query
// takes one bitmap read only. An allocate that hits the one-entry free cache
// takes one read and one write-back too. Otherwise allocate runs a next-fit
// scan through the bitmap ram, one byte per cycle through its single read
// port, starting at the byte of the last scan allocation and wrapping to
// byte 1 (byte 0 is never scanned). The output register lets the next input
// beat be taken while a result still waits.
`default_nettype none

module bitmap_frame_allocator
  import bfa_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output      logic in_ready_o,
  input  wire in_t  in_i,
  output      logic out_valid_o,
  input  wire logic out_ready_i,
  output      out_t out_o
);

`include "bitmap_frame_allocator_macros.svh"

  localparam logic [ByteIdxW-1:0] LastByte = ByteIdxW'(BitmapBytes - 1);
  localparam logic [ByteIdxW-1:0] FirstScanByte = ByteIdxW'(1);

  // control state
  state_e              state_q, state_d;
  logic [ByteIdxW-1:0] clr_q, clr_d;
  logic                cached_valid_q, cached_valid_d;
  logic [FrameW-1:0]   cached_frame_q, cached_frame_d;
  logic [ByteIdxW-1:0] next_fit_q, next_fit_d;
  logic [ByteIdxW-1:0] scan_ptr_q, scan_ptr_d;
  logic [ByteIdxW-1:0] scan_iss_q, scan_iss_d;   // bytes read so far in this scan
  logic                pend_q, pend_d;           // a scan read is in flight
  logic                out_valid_q, out_valid_d;

  // payload state
  logic [ByteIdxW-1:0] pend_addr_q, pend_addr_d;
  func_e               op_q, op_d;
  logic [FrameW-1:0]   frame_q, frame_d;
  out_t                res_q, res_d;
  out_t                out_q, out_d;

  // bitmap memory port
  logic                ram_we, ram_re;
  logic [ByteIdxW-1:0] ram_waddr, ram_raddr;
  logic [7:0]          ram_wdata, ram_rdata;

  byte_info_t          info;
  logic [2:0]          info_bit;
  logic [FrameW-1:0]   in_frame;
  logic [ByteIdxW-1:0] scan_start;
  logic                in_fire, scan_issue;

  bfa_ram #(
    .Width (8),
    .Depth (BitmapBytes)
  ) u_bitmap (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // during a scan only the lowest free bit matters, so the bit index is free
  assign info_bit = frame_q[2:0];

  bfa_byte_logic u_byte (
    .byte_i (ram_rdata),
    .bit_i  (info_bit),
    .info_o (info)
  );

  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign in_frame    = addr_to_frame(in_i.req_addr);
  assign scan_start  = (next_fit_q == '0) ? FirstScanByte : next_fit_q;
  assign scan_issue  = (scan_iss_q != LastByte);
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_CLEAR;
      clr_q          <= '0;
      cached_valid_q <= 1'b0;
      cached_frame_q <= '0;
      next_fit_q     <= FirstScanByte;
      scan_ptr_q     <= '0;
      scan_iss_q     <= '0;
      pend_q         <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      state_q        <= state_d;
      clr_q          <= clr_d;
      cached_valid_q <= cached_valid_d;
      cached_frame_q <= cached_frame_d;
      next_fit_q     <= next_fit_d;
      scan_ptr_q     <= scan_ptr_d;
      scan_iss_q     <= scan_iss_d;
      pend_q         <= pend_d;
      out_valid_q    <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_addr_q <= pend_addr_d;
    op_q        <= op_d;
    frame_q     <= frame_d;
    res_q       <= res_d;
    out_q       <= out_d;
  end

  always_comb begin
    state_d        = state_q;
    clr_d          = clr_q;
    cached_valid_d = cached_valid_q;
    cached_frame_d = cached_frame_q;
    next_fit_d     = next_fit_q;
    scan_ptr_d     = scan_ptr_q;
    scan_iss_d     = scan_iss_q;
    pend_d         = pend_q;
    pend_addr_d    = pend_addr_q;
    op_d           = op_q;
    frame_d        = frame_q;
    res_d          = res_q;
    out_d          = out_q;
    out_valid_d    = out_valid_q;

    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    ram_re    = 1'b0;
    ram_raddr = '0;

    // output slot drains independently of the work in progress
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = '0;
        clr_d     = clr_q + 1'b1;
        if (clr_q == LastByte) begin
          state_d = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (in_fire) begin
          op_d             = in_i.func;
          res_d            = '0;
          res_d.status     = STAT_OK;
          if (in_i.func == FUNC_ALLOC) begin
            if (cached_valid_q) begin
              // hand out the cached frame, its bit is set on write-back
              frame_d        = cached_frame_q;
              cached_valid_d = 1'b0;
              ram_re         = 1'b1;
              ram_raddr      = cached_frame_q[FrameW-1:3];
              state_d        = ST_RMW;
            end else begin
              scan_ptr_d = scan_start;
              scan_iss_d = '0;
              pend_d     = 1'b0;
              state_d    = ST_SCAN;
            end
          end else if (!addr_ok(in_i.req_addr)) begin
            res_d.status = STAT_BAD_ADDR;
            state_d      = ST_RESP;
          end else begin
            frame_d   = in_frame;
            ram_re    = 1'b1;
            ram_raddr = in_frame[FrameW-1:3];
            state_d   = ST_RMW;
          end
        end
      end

      ST_RMW: begin
        ram_waddr = frame_q[FrameW-1:3];
        unique case (op_q)
          FUNC_ALLOC: begin
            ram_we            = 1'b1;
            ram_wdata         = info.set_data;
            res_d.result_addr = frame_to_addr(frame_q);
          end
          FUNC_FREE: begin
            ram_we         = 1'b1;
            ram_wdata      = info.clr_data;
            cached_frame_d = frame_q;
            cached_valid_d = 1'b1;
          end
          FUNC_QUERY: begin
            res_d.frame_free = !info.bit_set;
          end
          FUNC_RESERVE: begin
            ram_we    = 1'b1;
            ram_wdata = info.set_data;
          end
          default: ;
        endcase
        state_d = ST_RESP;
      end

      ST_SCAN: begin
        if (pend_q && !info.full) begin
          // byte with a free bit found, take its lowest free bit
          ram_we            = 1'b1;
          ram_waddr         = pend_addr_q;
          ram_wdata         = info.take_data;
          next_fit_d        = pend_addr_q;
          res_d.result_addr = frame_to_addr({pend_addr_q, info.low_bit});
          pend_d            = 1'b0;
          state_d           = ST_RESP;
        end else if (!scan_issue && !pend_q) begin
          res_d.status = STAT_NO_FRAME;
          state_d      = ST_RESP;
        end else begin
          pend_d      = scan_issue;
          pend_addr_d = scan_ptr_q;
          if (scan_issue) begin
            ram_re     = 1'b1;
            ram_raddr  = scan_ptr_q;
            scan_iss_d = scan_iss_q + 1'b1;
            scan_ptr_d = (scan_ptr_q == LastByte) ? FirstScanByte : scan_ptr_q + 1'b1;
          end
        end
      end

      ST_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // the bitmap is only written while an item or the clearing pass is active
  `BFA_ASSERT_NOW(a_no_write_idle, clk_i, rst_ni, state_q == ST_IDLE, !ram_we,
                  "bitmap written while idle")

  // a scan never reads more bytes than the bitmap scan range holds
  `BFA_ASSERT_NOW(a_scan_bound, clk_i, rst_ni, state_q == ST_SCAN,
                  scan_iss_q <= LastByte, "scan ran past the bitmap")

  // only a successful allocation carries an address
  `BFA_ASSERT_NOW(a_addr_only_ok, clk_i, rst_ni,
                  out_valid_q && (out_q.status != STAT_OK),
                  out_q.result_addr == '0, "address on a failed result")

  // a free-frame answer only comes with an ok status
  `BFA_ASSERT_NOW(a_free_only_ok, clk_i, rst_ni, out_valid_q && out_q.frame_free,
                  out_q.status == STAT_OK, "frame_free with error status")

  // an accepted free leaves a frame in the cache once written back
  `BFA_ASSERT_NEXT(a_free_caches, clk_i, rst_ni,
                   state_q == ST_RMW && op_q == FUNC_FREE, cached_valid_q,
                   "free did not fill the cache")

endmodule

`default_nettype wire

// ===== bench/tb_bitmap_frame_allocator.sv =====
// self-checking testbench of the bitmap frame allocator with its own frame map predictor
`timescale 1ns / 1ps

module tb_bitmap_frame_allocator;
  import bfa_pkg::*;

  // limit covers the longest scan, plus the clearing pass and output stalls
  localparam int unsigned STALL_LIMIT = 20000;
  localparam int unsigned MAX_REPORTS = 10;
  localparam int unsigned CHUNKS      = 12;
  localparam int unsigned CHUNK_OPS   = 100;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic in_valid  = 1'b0;
  logic in_ready;
  in_t  in_beat   = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_beat;

  // requests waiting for the driver, replies the allocator still owes
  in_t  pending_frame_ops[$];
  out_t expected_replies[$];

  // beat on the request bus not yet accepted
  logic        req_outstanding = 1'b0;
  logic        no_idle         = 1'b0;
  int unsigned quiet_cycles    = 0;
  logic        beat_seen;

  // predictor copy of the allocator state
  logic [7:0]          used_map[BitmapBytes];
  logic                cache_vld;
  logic [FrameW-1:0]   cache_frame;
  logic [ByteIdxW-1:0] fit_byte;

  int unsigned req_cnt      = 0;
  int unsigned reply_cnt    = 0;
  int unsigned mismatch_cnt = 0;
  int unsigned cache_hits   = 0;
  int unsigned scan_hits    = 0;
  int unsigned no_frame_cnt = 0;
  int unsigned bad_addr_cnt = 0;

  bitmap_frame_allocator dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_i        (in_beat),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_o       (out_beat)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // takes the lowest clear bit of one map byte, moving the next-fit pointer there
  function automatic logic take_lowest(int unsigned idx, output logic [FrameW-1:0] frame);
    frame = '0;
    if (used_map[idx] == 8'hFF) return 1'b0;
    for (int unsigned b = 0; b < 8; b++) begin
      if (!used_map[idx][b]) begin
        used_map[idx][b] = 1'b1;
        fit_byte = ByteIdxW'(idx);
        frame = FrameW'(idx * 8 + b);
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // applies one request to the predicted map and returns the reply it owes
  function automatic out_t predict_frame_op(in_t op);
    out_t              rep;
    logic [FrameW-1:0] fr;
    logic              got;
    int unsigned       start;
    rep        = '0;
    rep.status = STAT_OK;
    fr         = '0;
    got        = 1'b0;
    if (op.func == FUNC_ALLOC) begin
      if (cache_vld) begin
        // cached frame goes out without looking at its bit
        used_map[cache_frame[FrameW-1:3]][cache_frame[2:0]] = 1'b1;
        fr        = cache_frame;
        cache_vld = 1'b0;
        got       = 1'b1;
        cache_hits++;
      end else begin
        // next fit from the remembered byte, then wrap to byte 1; byte 0 is skipped
        start = (fit_byte == '0) ? 1 : fit_byte;
        for (int unsigned i = start; i < BitmapBytes && !got; i++) got = take_lowest(i, fr);
        for (int unsigned i = 1; i < start && !got; i++) got = take_lowest(i, fr);
        if (got) scan_hits++;
      end
      if (got) begin
        rep.result_addr = AddrW'({fr, {FrameShift{1'b0}}});
      end else begin
        rep.status = STAT_NO_FRAME;
        no_frame_cnt++;
      end
    end else if (op.req_addr[FrameShift-1:0] != '0) begin
      // every 25-bit address lies inside the map, so only alignment can fail
      rep.status = STAT_BAD_ADDR;
      bad_addr_cnt++;
    end else begin
      fr = op.req_addr[AddrW-1:FrameShift];
      case (op.func)
        FUNC_FREE: begin
          used_map[fr[FrameW-1:3]][fr[2:0]] = 1'b0;
          cache_frame = fr;
          cache_vld   = 1'b1;
        end
        FUNC_QUERY: begin
          rep.frame_free = ~used_map[fr[FrameW-1:3]][fr[2:0]];
        end
        default: begin
          // mark used leaves the cache alone
          used_map[fr[FrameW-1:3]][fr[2:0]] = 1'b1;
        end
      endcase
    end
    return rep;
  endfunction

  function automatic in_t random_frame_op(int unsigned alloc_pct);
    in_t         op;
    int unsigned roll;
    roll          = $urandom_range(99);
    op.func       = FUNC_ALLOC;
    op.req_addr   = AddrW'($urandom);
    if (roll >= alloc_pct) begin
      if (roll < 65) begin
        op.func = FUNC_FREE;
      end else if (roll < 85) begin
        op.func = FUNC_QUERY;
      end else begin
        op.func = FUNC_RESERVE;
      end
      // mostly aligned frames, the rest keep the raw random address, mostly unaligned
      if ($urandom_range(9) != 0) op.req_addr = AddrW'({FrameW'($urandom), {FrameShift{1'b0}}});
    end
    return op;
  endfunction

  task automatic queue_op(func_e f, logic [AddrW-1:0] a);
    in_t op;
    op.func     = f;
    op.req_addr = a;
    pending_frame_ops.push_back(op);
  endtask

  // holds the sender until every reply has come back
  task automatic wait_for_drain();
    do @(negedge clk_i);
    while (pending_frame_ops.size() != 0 || req_outstanding || expected_replies.size() != 0);
    @(posedge clk_i);
  endtask

  // driver: request beats and output ready change at the falling edge
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid  <= 1'b0;
      out_ready <= 1'b0;
    end else begin
      if (!req_outstanding) begin
        if (pending_frame_ops.size() != 0 && (no_idle || $urandom_range(99) >= 20)) begin
          in_beat         <= pending_frame_ops.pop_front();
          in_valid        <= 1'b1;
          req_outstanding = 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_ready <= no_idle || ($urandom_range(99) >= 20);
    end
  end

  // monitor: both handshakes sampled at the rising edge
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      for (int unsigned i = 0; i < BitmapBytes; i++) used_map[i] = 8'h00;
      cache_vld    = 1'b0;
      cache_frame  = '0;
      fit_byte     = ByteIdxW'(1);
      quiet_cycles = 0;
    end else begin
      beat_seen = 1'b0;
      if (in_valid && in_ready) begin
        expected_replies.push_back(predict_frame_op(in_beat));
        req_outstanding = 1'b0;
        req_cnt++;
        beat_seen = 1'b1;
      end
      if (out_valid && out_ready) begin
        beat_seen = 1'b1;
        reply_cnt++;
        if (expected_replies.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= MAX_REPORTS)
            $display("reply with nothing outstanding: addr %0h status %0d free %0b",
                     out_beat.result_addr, out_beat.status, out_beat.frame_free);
        end else begin
          out_t want;
          want = expected_replies.pop_front();
          if (out_beat.result_addr !== want.result_addr || out_beat.status !== want.status ||
              out_beat.frame_free !== want.frame_free) begin
            mismatch_cnt++;
            if (mismatch_cnt <= MAX_REPORTS)
              $display("reply %0d wrong: addr %0h/%0h status %0d/%0d free %0b/%0b (exp/got)",
                       reply_cnt, want.result_addr, out_beat.result_addr, want.status,
                       out_beat.status, want.frame_free, out_beat.frame_free);
          end
        end
      end
      if (beat_seen || !(pending_frame_ops.size() != 0 || req_outstanding ||
                         expected_replies.size() != 0))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
  end

  initial begin : watchdog
    while (quiet_cycles < STALL_LIMIT) @(negedge clk_i);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin : stimulus
    int unsigned alloc_pct;
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed part on an empty map
    queue_op(FUNC_ALLOC,   25'h0000000);  // first scan hit, byte 1 bit 0
    queue_op(FUNC_ALLOC,   25'h1FFFFFF);  // address field ignored on allocate
    queue_op(FUNC_QUERY,   25'h0008000);
    queue_op(FUNC_QUERY,   25'h1FFF000);  // top frame
    queue_op(FUNC_QUERY,   25'h1FFFFFF);  // unaligned
    queue_op(FUNC_FREE,    25'h0000001);
    queue_op(FUNC_RESERVE, 25'h0000800);
    queue_op(FUNC_FREE,    25'h0000000);  // frame 0 lives in the never scanned byte
    queue_op(FUNC_ALLOC,   25'h0000000);  // cache hands back address zero
    queue_op(FUNC_QUERY,   25'h0000000);
    queue_op(FUNC_FREE,    25'h0008000);
    queue_op(FUNC_RESERVE, 25'h0008000);  // reserving the cached frame
    queue_op(FUNC_ALLOC,   25'h0000000);  // still handed out from the cache
    queue_op(FUNC_FREE,    25'h1FFF000);  // freeing a frame that is already free
    queue_op(FUNC_FREE,    25'h0009000);  // overwrites the cached frame
    queue_op(FUNC_ALLOC,   25'h0000000);
    queue_op(FUNC_ALLOC,   25'h1555555);
    queue_op(FUNC_RESERVE, 25'h1FFF000);
    queue_op(FUNC_QUERY,   25'h1FFF000);
    queue_op(FUNC_QUERY,   25'h0001000);
    queue_op(FUNC_RESERVE, 25'h0001000);
    queue_op(FUNC_QUERY,   25'h0AAAFFF);
    queue_op(FUNC_FREE,    25'h1FFE000);
    wait_for_drain();

    // move the next-fit byte across a few full bytes, then punch holes
    repeat (40) queue_op(FUNC_ALLOC, AddrW'($urandom));
    queue_op(FUNC_QUERY,   25'h0008000);
    queue_op(FUNC_FREE,    25'h0018000);  // hole behind the next-fit byte
    queue_op(FUNC_FREE,    25'h0064000);  // cached
    queue_op(FUNC_ALLOC,   25'h0000000);  // from the cache
    queue_op(FUNC_ALLOC,   25'h0000000);  // scan goes on past the hole
    queue_op(FUNC_QUERY,   25'h0018000);
    queue_op(FUNC_RESERVE, 25'h0000010);  // unaligned
    wait_for_drain();

    // random part: churn on a crowded map, alternating allocation bias
    for (int unsigned c = 0; c < CHUNKS; c++) begin
      if (c % 3 == 0) begin
        wait_for_drain();
        no_idle = (c == 6);
      end
      case (c % 3)
        0:       alloc_pct = 35;
        1:       alloc_pct = 20;
        default: alloc_pct = 50;
      endcase
      repeat (CHUNK_OPS) pending_frame_ops.push_back(random_frame_op(alloc_pct));
    end
    wait_for_drain();
    repeat (16) @(negedge clk_i);

    $display("covered %0d requests: %0d scan allocations, %0d cache allocations, %0d exhausted",
             req_cnt, scan_hits, cache_hits, no_frame_cnt);
    $display("%0d misaligned addresses rejected, %0d replies checked, %0d mismatches",
             bad_addr_cnt, reply_cnt, mismatch_cnt);
    if (mismatch_cnt == 0 && expected_replies.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
